### hw/rtl/hkm_pkg.sv
// shared types, codes and key position table for the hid keycode to key matrix core
package hkm_pkg;

    localparam int ROW_COUNT = 8;
    localparam int ROW_W     = 6;
    localparam int ROW_AW    = 3;
    localparam int COL_AW    = 3;

    localparam logic [ROW_W-1:0] ROW_IDLE = 6'b111111;

    // kind codes of an input item
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // modifier and special usage codes
    localparam logic [7:0] CODE_LSHIFT = 8'hE1;
    localparam logic [7:0] CODE_RSHIFT = 8'hE5;
    localparam logic [7:0] CODE_LCTRL  = 8'hE0;
    localparam logic [7:0] CODE_RCTRL  = 8'hE4;
    localparam logic [7:0] CODE_SPACE  = 8'h2C;
    localparam logic [7:0] CODE_ENTER  = 8'h28;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key_code;
        logic [7:0] row_select;
    } t_in_item;

    typedef struct packed {
        logic [5:0] row_data;
        logic       code_mapped;
    } t_out_item;

    typedef struct packed {
        logic              mapped;
        logic [ROW_AW-1:0] row;
        logic [COL_AW-1:0] col;
    } t_key_pos;

    // one matrix write: clear (press) or set (release) one key bit
    typedef struct packed {
        logic              en;
        logic              set;
        logic [ROW_AW-1:0] row;
        logic [COL_AW-1:0] col;
    } t_mat_upd;

    function automatic t_key_pos key_lookup(input logic [7:0] code);
        t_key_pos p;
        p = '{mapped: 1'b1, row: '0, col: '0};
        case (code)
            8'h15: begin p.row = 3'd0; p.col = 3'd5; end
            8'h14: begin p.row = 3'd0; p.col = 3'd4; end
            8'h08: begin p.row = 3'd0; p.col = 3'd3; end
            8'h1A: begin p.row = 3'd0; p.col = 3'd1; end
            8'h17: begin p.row = 3'd0; p.col = 3'd0; end
            8'h09: begin p.row = 3'd1; p.col = 3'd5; end
            8'h04: begin p.row = 3'd1; p.col = 3'd4; end
            8'h07: begin p.row = 3'd1; p.col = 3'd3; end
            8'h16: begin p.row = 3'd1; p.col = 3'd1; end
            8'h0A: begin p.row = 3'd1; p.col = 3'd0; end
            8'h19: begin p.row = 3'd2; p.col = 3'd5; end
            8'h1D: begin p.row = 3'd2; p.col = 3'd4; end
            8'h06: begin p.row = 3'd2; p.col = 3'd3; end
            8'h1B: begin p.row = 3'd2; p.col = 3'd1; end
            8'h05: begin p.row = 3'd2; p.col = 3'd0; end
            8'h21: begin p.row = 3'd3; p.col = 3'd5; end
            8'h1E: begin p.row = 3'd3; p.col = 3'd4; end
            8'h20: begin p.row = 3'd3; p.col = 3'd3; end
            8'h1F: begin p.row = 3'd3; p.col = 3'd1; end
            8'h22: begin p.row = 3'd3; p.col = 3'd0; end
            8'h10: begin p.row = 3'd4; p.col = 3'd5; end
            CODE_SPACE: begin p.row = 3'd4; p.col = 3'd4; end
            8'h36: begin p.row = 3'd4; p.col = 3'd3; end
            8'h37: begin p.row = 3'd4; p.col = 3'd1; end
            8'h11: begin p.row = 3'd4; p.col = 3'd0; end
            8'h24: begin p.row = 3'd5; p.col = 3'd5; end
            8'h27: begin p.row = 3'd5; p.col = 3'd4; end
            8'h25: begin p.row = 3'd5; p.col = 3'd3; end
            8'h2D: begin p.row = 3'd5; p.col = 3'd2; end
            8'h26: begin p.row = 3'd5; p.col = 3'd1; end
            8'h23: begin p.row = 3'd5; p.col = 3'd0; end
            8'h18: begin p.row = 3'd6; p.col = 3'd5; end
            8'h13: begin p.row = 3'd6; p.col = 3'd4; end
            8'h0C: begin p.row = 3'd6; p.col = 3'd3; end
            CODE_ENTER: begin p.row = 3'd6; p.col = 3'd2; end
            8'h12: begin p.row = 3'd6; p.col = 3'd1; end
            8'h1C: begin p.row = 3'd6; p.col = 3'd0; end
            8'h0D: begin p.row = 3'd7; p.col = 3'd5; end
            8'h33: begin p.row = 3'd7; p.col = 3'd4; end
            8'h0E: begin p.row = 3'd7; p.col = 3'd3; end
            8'h34: begin p.row = 3'd7; p.col = 3'd2; end
            8'h0F: begin p.row = 3'd7; p.col = 3'd1; end
            8'h0B: begin p.row = 3'd7; p.col = 3'd0; end
            CODE_LSHIFT: begin p.row = 3'd2; p.col = 3'd2; end
            CODE_RSHIFT: begin p.row = 3'd2; p.col = 3'd2; end
            CODE_LCTRL:  begin p.row = 3'd1; p.col = 3'd2; end
            CODE_RCTRL:  begin p.row = 3'd1; p.col = 3'd2; end
            default: begin p.mapped = 1'b0; end
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/hkm_matrix.sv
// active-low key matrix image with single-bit update and row read
module hkm_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hkm_pkg::t_mat_upd             i_upd,
    input  logic [hkm_pkg::ROW_COUNT-1:0] i_row_select,
    output logic [hkm_pkg::ROW_W-1:0]     o_row_data
);

    logic [hkm_pkg::ROW_W-1:0] r_rows [hkm_pkg::ROW_COUNT];
    logic [hkm_pkg::ROW_W-1:0] n_row;
    logic [hkm_pkg::ROW_W-1:0] col_mask;

    assign col_mask = hkm_pkg::ROW_W'(1) << i_upd.col;

    always_comb begin
        if (i_upd.set) begin
            n_row = r_rows[i_upd.row] | col_mask;
        end else begin
            n_row = r_rows[i_upd.row] & ~col_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hkm_pkg::ROW_COUNT; i++) begin
                r_rows[i] <= hkm_pkg::ROW_IDLE;
            end
        end else if (i_upd.en) begin
            r_rows[i_upd.row] <= n_row;
        end
    end

    // and of every row whose select bit is low
    always_comb begin
        o_row_data = hkm_pkg::ROW_IDLE;
        for (int i = 0; i < hkm_pkg::ROW_COUNT; i++) begin
            if (!i_row_select[i]) begin
                o_row_data = o_row_data & r_rows[i];
            end
        end
    end

endmodule

### hw/rtl/hid_keycode_to_key_matrix_core.sv
// top level of the hid keycode to key matrix core
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------
//  input   | i_in_valid | o_in_ready  | i_in_data  (t_in_item)
//  result  | o_out_valid| i_out_ready | o_out_data (t_out_item)
//
// two register stages: an input register, then a result register; one item
// per cycle sustained while the result side keeps taking results
// the key lookup, matrix update and row read all sit between the two registers
// synchronous active-low reset empties both stages and releases every key
// a stall on the result side holds the result register, then the input
// register, and finally drops o_in_ready; nothing is lost or repeated
module hid_keycode_to_key_matrix_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hkm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hkm_pkg::t_out_item o_out_data
);

    logic               r_s1_valid;
    hkm_pkg::t_in_item  r_s1_item;
    logic               r_out_valid;
    hkm_pkg::t_out_item r_out_item;

    logic               out_free;
    logic               s1_move;
    logic               in_xfer;
    hkm_pkg::t_key_pos  pos;
    hkm_pkg::t_mat_upd  upd;
    logic [hkm_pkg::ROW_W-1:0] rd_data;
    hkm_pkg::t_out_item n_out_item;

    // pipeline flow: the result register frees up when empty or taken
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // table lookup runs on every item, reads included
    assign pos = hkm_pkg::key_lookup(r_s1_item.key_code);

    // matrix write only when the item leaves stage one
    always_comb begin
        upd.en  = s1_move && pos.mapped &&
                  (r_s1_item.kind == hkm_pkg::KIND_PRESS ||
                   r_s1_item.kind == hkm_pkg::KIND_RELEASE);
        upd.set = (r_s1_item.kind == hkm_pkg::KIND_RELEASE);
        upd.row = pos.row;
        upd.col = pos.col;
    end

    hkm_matrix u_matrix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (upd),
        .i_row_select (r_s1_item.row_select),
        .o_row_data   (rd_data)
    );

    // read sees all earlier updates, since those committed in earlier cycles
    always_comb begin
        n_out_item.code_mapped = pos.mapped;
        if (r_s1_item.kind == hkm_pkg::KIND_READ) begin
            n_out_item.row_data = rd_data;
        end else begin
            n_out_item.row_data = hkm_pkg::ROW_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_data;
        end
        if (s1_move) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

### tb/sv/key_matrix_result_check.sv
// result checker for the hid keycode to key matrix core: key matrix predictor and compare
module key_matrix_result_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  hkm_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  hkm_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic               code_known [256];
    logic [2:0]         code_row   [256];
    logic [2:0]         code_bit   [256];
    logic [5:0]         key_rows   [8];
    hkm_pkg::t_out_item expected_results [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic place_key(input logic [7:0] code, input int row, input int col);
        code_known[code] = 1'b1;
        code_row[code]   = row[2:0];
        code_bit[code]   = col[2:0];
    endtask

    initial begin
        for (int c = 0; c < 256; c++) begin
            code_known[c] = 1'b0;
            code_row[c]   = '0;
            code_bit[c]   = '0;
        end
        place_key(8'h15, 0, 5); place_key(8'h14, 0, 4); place_key(8'h08, 0, 3);
        place_key(8'h1A, 0, 1); place_key(8'h17, 0, 0);
        place_key(8'h09, 1, 5); place_key(8'h04, 1, 4); place_key(8'h07, 1, 3);
        place_key(8'h16, 1, 1); place_key(8'h0A, 1, 0);
        place_key(8'h19, 2, 5); place_key(8'h1D, 2, 4); place_key(8'h06, 2, 3);
        place_key(8'h1B, 2, 1); place_key(8'h05, 2, 0);
        place_key(8'h21, 3, 5); place_key(8'h1E, 3, 4); place_key(8'h20, 3, 3);
        place_key(8'h1F, 3, 1); place_key(8'h22, 3, 0);
        place_key(8'h10, 4, 5); place_key(8'h2C, 4, 4); place_key(8'h36, 4, 3);
        place_key(8'h37, 4, 1); place_key(8'h11, 4, 0);
        place_key(8'h24, 5, 5); place_key(8'h27, 5, 4); place_key(8'h25, 5, 3);
        place_key(8'h2D, 5, 2); place_key(8'h26, 5, 1); place_key(8'h23, 5, 0);
        place_key(8'h18, 6, 5); place_key(8'h13, 6, 4); place_key(8'h0C, 6, 3);
        place_key(8'h28, 6, 2); place_key(8'h12, 6, 1); place_key(8'h1C, 6, 0);
        place_key(8'h0D, 7, 5); place_key(8'h33, 7, 4); place_key(8'h0E, 7, 3);
        place_key(8'h34, 7, 2); place_key(8'h0F, 7, 1); place_key(8'h0B, 7, 0);
        // both shifts share one matrix key, both controls another
        place_key(8'hE1, 2, 2); place_key(8'hE5, 2, 2);
        place_key(8'hE0, 1, 2); place_key(8'hE4, 1, 2);
    end

    task automatic report_mismatch(input string what);
        $display("%0t: result mismatch: %s", $time, what);
        mismatches++;
    endtask

    // updates the matrix image for one key event and returns the result it gives
    function automatic hkm_pkg::t_out_item apply_key_event(input hkm_pkg::t_in_item ev);
        hkm_pkg::t_out_item res;
        logic               known;
        logic [2:0]         row;
        logic [2:0]         col;
        known           = code_known[ev.key_code];
        row             = code_row[ev.key_code];
        col             = code_bit[ev.key_code];
        res.row_data    = hkm_pkg::ROW_IDLE;
        res.code_mapped = known;
        case (ev.kind)
            hkm_pkg::KIND_PRESS: begin
                if (known) key_rows[row][col] = 1'b0;
            end
            hkm_pkg::KIND_RELEASE: begin
                if (known) key_rows[row][col] = 1'b1;
            end
            hkm_pkg::KIND_READ: begin
                for (int r = 0; r < 8; r++)
                    if (!ev.row_select[r]) res.row_data &= key_rows[r];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        hkm_pkg::t_out_item want;
        if (!i_rst_n) begin
            expected_results.delete();
            for (int r = 0; r < 8; r++) key_rows[r] = hkm_pkg::ROW_IDLE;
        end else begin
            // a result never belongs to the input taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", i_out_data));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.row_data !== want.row_data)
                        report_mismatch($sformatf("row_data %h, want %h",
                                                  i_out_data.row_data, want.row_data));
                    if (i_out_data.code_mapped !== want.code_mapped)
                        report_mismatch($sformatf("code_mapped %b, want %b",
                                                  i_out_data.code_mapped, want.code_mapped));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_key_event(i_in_data));
        end
        o_pending <= expected_results.size();
    end

endmodule

### tb/sv/tb_hid_keycode_to_key_matrix_core.sv
// testbench top for the hid keycode to key matrix core: stimulus, flow control and verdict
module tb_hid_keycode_to_key_matrix_core;

    // kind code the block has no use for; it must leave the matrix alone
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         EVENT_TOTAL = 1950;
    localparam int         HOLD_CYCLES = 40;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    hkm_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    hkm_pkg::t_out_item out_data;

    int   fail_count;
    int   pending;
    // percent of cycles in which each side idles; zeroed for a stretch
    int   idle_pct     = 38;
    // set by the stimulus to make the result side hold off for a while
    logic hold_results = 1'b0;

    hid_keycode_to_key_matrix_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    key_matrix_result_check u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random back-pressure, or a long counted hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_results) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // offer one item after random idle cycles and hold it until the transfer
    task automatic send_item(input hkm_pkg::t_in_item ev);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        // ready as seen just after the edge is the value the transfer used
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [7:0] code,
                               input logic [7:0] sel);
        hkm_pkg::t_in_item ev;
        ev.kind       = kind;
        ev.key_code   = code;
        ev.row_select = sel;
        send_item(ev);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly plausible keyboard traffic, with some raw noise mixed in
    function automatic hkm_pkg::t_in_item random_item();
        hkm_pkg::t_in_item ev;
        int                pick;
        int                sel_pick;
        pick          = $urandom_range(99);
        ev.key_code   = ($urandom_range(3) == 0) ? 8'(8'hE0 + $urandom_range(7))
                                                 : 8'($urandom_range(8'h04, 8'h37));
        ev.row_select = 8'($urandom_range(255));
        if (pick < 20) begin
            // noise: any kind, any code, any row address
            ev.kind     = 2'($urandom_range(3));
            ev.key_code = 8'($urandom_range(255));
        end else if (pick < 48) begin
            ev.kind = hkm_pkg::KIND_PRESS;
        end else if (pick < 74) begin
            ev.kind = hkm_pkg::KIND_RELEASE;
        end else begin
            ev.kind     = hkm_pkg::KIND_READ;
            ev.key_code = 8'($urandom_range(255));
            sel_pick    = $urandom_range(99);
            // single rows dominate, as a real scan would
            if (sel_pick < 50)      ev.row_select = ~(8'd1 << $urandom_range(7));
            else if (sel_pick < 65) ev.row_select = 8'h00;
            else if (sel_pick < 75) ev.row_select = 8'hFF;
        end
        return ev;
    endfunction

    initial begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty matrix reads, corner rows, shared modifiers,
        // unmapped codes, repeats, unused kind, lookup on a read
        send_fields(hkm_pkg::KIND_READ,    8'h00, 8'h00);
        send_fields(hkm_pkg::KIND_READ,    8'hFF, 8'hFF);
        send_fields(hkm_pkg::KIND_PRESS,   8'h15, 8'hFF);
        send_fields(hkm_pkg::KIND_PRESS,   8'h0B, 8'h00);
        send_fields(hkm_pkg::KIND_READ,    8'h15, 8'hFE);
        send_fields(hkm_pkg::KIND_READ,    8'h0B, 8'h7F);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_LSHIFT, 8'h00);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_RSHIFT, 8'h00);
        // releasing one shift lets go of the shared key
        send_fields(hkm_pkg::KIND_RELEASE, hkm_pkg::CODE_LSHIFT, 8'h00);
        send_fields(hkm_pkg::KIND_READ,    8'h00, 8'hFB);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_LCTRL, 8'h00);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_RCTRL, 8'h00);
        send_fields(hkm_pkg::KIND_RELEASE, hkm_pkg::CODE_RCTRL, 8'h00);
        send_fields(hkm_pkg::KIND_READ,    8'h00, 8'hFD);
        send_fields(hkm_pkg::KIND_PRESS,   8'h00, 8'h00);
        send_fields(hkm_pkg::KIND_RELEASE, 8'hFF, 8'hFF);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_SPACE, 8'h00);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_SPACE, 8'h00);
        send_fields(hkm_pkg::KIND_RELEASE, hkm_pkg::CODE_ENTER, 8'h00);
        send_fields(hkm_pkg::KIND_PRESS,   hkm_pkg::CODE_ENTER, 8'h00);
        send_fields(KIND_UNUSED,           hkm_pkg::CODE_SPACE, 8'h00);
        send_fields(hkm_pkg::KIND_READ,    8'hAA, 8'h00);
        send_fields(hkm_pkg::KIND_RELEASE, 8'h15, 8'h55);
        send_fields(hkm_pkg::KIND_RELEASE, hkm_pkg::CODE_SPACE, 8'h00);
        send_fields(hkm_pkg::KIND_READ,    hkm_pkg::CODE_ENTER, 8'h00);

        for (n = 0; n < EVENT_TOTAL; n++) begin
            // sender waits out every pending result now and then
            if (n == 300 || n == 1400) drain_results();
            // long result hold-off while the sender keeps offering
            if (n == 700) hold_results = 1'b1;
            idle_pct = (n >= 900 && n < 1150) ? 0 : 38;
            send_item(random_item());
        end

        drain_results();
        // catch any stray result after the last expected one
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/hkm_pkg.sv
hw/rtl/hkm_matrix.sv
hw/rtl/hid_keycode_to_key_matrix_core.sv
tb/sv/key_matrix_result_check.sv
tb/sv/tb_hid_keycode_to_key_matrix_core.sv
